// ===== rtl/core/divider_and_reload_timer_assert.svh =====
// Assertion macros shared by the timer checker.
`ifndef DIVIDER_AND_RELOAD_TIMER_ASSERT_SVH
`define DIVIDER_AND_RELOAD_TIMER_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define DRTMR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("drtmr: implication check failed");

// Next-cycle implication, masked while reset is held.
`define DRTMR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("drtmr: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define DRTMR_ASSERT_NXT_ANY(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("drtmr: reset-time check failed");

`endif

// ===== rtl/core/drtmr_pkg.sv =====
// Shared types, constants and helpers of the divider and reload timer.
`timescale 1ns / 1ps
package drtmr_pkg;

  // Divider period in machine cycles (16 to 256)
  localparam int unsigned DIV_PERIOD = 256;

  localparam int unsigned DIV_ACC_W  = 9;
  localparam int unsigned TMR_ACC_W  = 11;
  localparam int unsigned CYC_W      = 8;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_TIMER_ENABLE = 2'd0;
  localparam logic [1:0] REG_CLOCK_SELECT = 2'd1;
  localparam logic [1:0] REG_RELOAD_VALUE = 2'd2;

  // Clock select codes
  localparam logic [1:0] CSEL_1024 = 2'd0;
  localparam logic [1:0] CSEL_16   = 2'd1;
  localparam logic [1:0] CSEL_64   = 2'd2;
  localparam logic [1:0] CSEL_256  = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  typedef struct packed {
    logic             timer_enable;
    logic [1:0]       clock_select;
    logic [CNT_W-1:0] reload_value;
  } cfg_t;

  typedef struct packed {
    logic             timer_interrupt;
    logic [CNT_W-1:0] timer_value;
    logic [CNT_W-1:0] divider_value;
  } res_t;

  // Timer period chosen by the clock select
  function automatic logic [TMR_ACC_W-1:0] tmr_period(input logic [1:0] csel);
    logic [TMR_ACC_W-1:0] p;
    unique case (csel)
      CSEL_1024: p = 11'd1024;
      CSEL_16:   p = 11'd16;
      CSEL_64:   p = 11'd64;
      CSEL_256:  p = 11'd256;
      default:   p = 11'd1024;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/drtmr_regs.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module drtmr_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [drtmr_pkg::ADDR_W-1:0]   paddr,
  input  logic [drtmr_pkg::PDATA_W-1:0]  pwdata,
  output logic [drtmr_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready,
  output drtmr_pkg::cfg_t                cfg
);
  import drtmr_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Update the addressed register on a completed write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_TIMER_ENABLE: cfg_nxt.timer_enable = pwdata[0];
        REG_CLOCK_SELECT: cfg_nxt.clock_select = pwdata[1:0];
        REG_RELOAD_VALUE: cfg_nxt.reload_value = pwdata[CNT_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register, zero-extended
  always_comb begin
    unique case (reg_idx)
      REG_TIMER_ENABLE: prdata = {{(PDATA_W-1){1'b0}}, cfg_r.timer_enable};
      REG_CLOCK_SELECT: prdata = {{(PDATA_W-2){1'b0}}, cfg_r.clock_select};
      REG_RELOAD_VALUE: prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_r.reload_value};
      default:          prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/drtmr_count.sv =====
// Divider and timer counter state with the single-step update logic.
`timescale 1ns / 1ps
module drtmr_count (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic [drtmr_pkg::CYC_W-1:0]   cycles,
  input  drtmr_pkg::cfg_t               cfg,
  output drtmr_pkg::res_t               res
);
  import drtmr_pkg::*;

  localparam logic [DIV_ACC_W-1:0] DIV_PERIOD_C = DIV_ACC_W'(DIV_PERIOD);

  logic [DIV_ACC_W-1:0] div_acc_r, div_acc_nxt, div_sum;
  logic [TMR_ACC_W-1:0] tmr_acc_r, tmr_acc_nxt, tmr_sum;
  logic [CNT_W-1:0]     div_r, div_nxt;
  logic [CNT_W-1:0]     tmr_r, tmr_nxt;
  logic                 irq;

  // Divider: add cycles, step once and drop any excess on reaching the period
  always_comb begin
    div_sum     = div_acc_r + DIV_ACC_W'(cycles);
    div_acc_nxt = div_sum;
    div_nxt     = div_r;
    if (div_sum >= DIV_PERIOD_C) begin
      div_acc_nxt = '0;
      div_nxt     = div_r + CNT_W'(1);
    end
  end

  // Timer: advance only while enabled, reload from the top value
  always_comb begin
    tmr_sum     = tmr_acc_r + TMR_ACC_W'(cycles);
    tmr_acc_nxt = tmr_acc_r;
    tmr_nxt     = tmr_r;
    irq         = 1'b0;
    if (cfg.timer_enable) begin
      tmr_acc_nxt = tmr_sum;
      if (tmr_sum >= tmr_period(cfg.clock_select)) begin
        tmr_acc_nxt = '0;
        if (tmr_r == CNT_MAX) begin
          tmr_nxt = cfg.reload_value;
          irq     = 1'b1;
        end else begin
          tmr_nxt = tmr_r + CNT_W'(1);
        end
      end
    end
  end

  // Commit the step when the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_acc_r <= '0;
      tmr_acc_r <= '0;
      div_r     <= '0;
      tmr_r     <= '0;
    end else if (step_en) begin
      div_acc_r <= div_acc_nxt;
      tmr_acc_r <= tmr_acc_nxt;
      div_r     <= div_nxt;
      tmr_r     <= tmr_nxt;
    end
  end

  assign res.divider_value   = div_nxt;
  assign res.timer_value     = tmr_nxt;
  assign res.timer_interrupt = irq;

endmodule

// ===== rtl/core/divider_and_reload_timer.sv =====
// Top level of the divider and reload timer: request pipeline and config port.
//
//   channel  | direction | carries
//   ---------+-----------+-------------------------------------------------
//   in_      | slave     | elapsed cycle count, one request per item
//   out_     | master    | divider value, timer value, interrupt flag
//   cfg_     | APB slave | timer_enable, clock_select, reload_value
//
// One request per clock sustained while out_tready is high; each request passes the
// input register, then the add/compare step, then the result register.
// Reset (rst_n low, synchronous) clears counters, config and both valid flags.
// A stalled result holds in the output register while the input register
// still takes one request; both sides stall only when both stages are full.
`timescale 1ns / 1ps
module divider_and_reload_timer (
  input  logic                                clk,
  input  logic                                rst_n,
  // tdata: [7:0] elapsed_cycles
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [drtmr_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tdata: [7:0] divider_value, [15:8] timer_value, [16] timer_interrupt,
  //        [23:17] zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [drtmr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [drtmr_pkg::ADDR_W-1:0]        cfg_paddr,
  input  logic [drtmr_pkg::PDATA_W-1:0]       cfg_pwdata,
  output logic [drtmr_pkg::PDATA_W-1:0]       cfg_prdata,
  output logic                                cfg_pready
);
  import drtmr_pkg::*;

  cfg_t             cfg;
  res_t             res;
  logic             s1_valid_r, s1_valid_nxt;
  logic [CYC_W-1:0] s1_cycles_r;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r;
  logic             advance;
  logic             take_in;

  drtmr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Move the held request to the result register when that is free
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign take_in   = in_tvalid && in_tready;

  drtmr_count u_count (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .cycles  (s1_cycles_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_comb begin
    s1_valid_nxt  = take_in || (s1_valid_r && !advance);
    out_valid_nxt = advance || (out_valid_r && !out_tready);
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_cycles_r <= in_tdata[CYC_W-1:0];
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.timer_interrupt, out_res_r.timer_value,
                       out_res_r.divider_value};

endmodule

// ===== rtl/core/drtmr_checker.sv =====
// Port-level checker for the divider and reload timer, bound to the top level.
`timescale 1ns / 1ps
`include "divider_and_reload_timer_assert.svh"
module drtmr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [drtmr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import drtmr_pkg::*;

  logic out_acc;
  assign out_acc = out_tvalid && out_tready;

  // No result straight after reset
  `DRTMR_ASSERT_NXT_ANY(a_no_result_after_reset, clk, !rst_n, !out_tvalid)

  // A stalled result holds
  `DRTMR_ASSERT_NXT(a_stall_holds, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Divider steps by at most one between back-to-back results
  `DRTMR_ASSERT_IMP(a_div_step, clk, rst_n, out_acc && $past(out_acc), (out_tdata[7:0] == $past(out_tdata[7:0])) || (out_tdata[7:0] == 8'($past(out_tdata[7:0]) + 8'd1)))

  // Without an interrupt the timer steps by at most one and never wraps
  `DRTMR_ASSERT_IMP(a_tmr_step, clk, rst_n, out_acc && $past(out_acc) && !out_tdata[16], (out_tdata[15:8] == $past(out_tdata[15:8])) || (out_tdata[15:8] == ($past(out_tdata[15:8]) + 8'd1) && $past(out_tdata[15:8]) != 8'hFF))

endmodule

bind divider_and_reload_timer drtmr_checker u_drtmr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/tb_divider_and_reload_timer.sv =====
// Self-checking testbench for the divider and reload timer: directed table, then random phases.
`timescale 1ns / 1ps
module tb_divider_and_reload_timer;
  import drtmr_pkg::*;

  // Address slot with no register behind it; writes there must change nothing
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int RAND_PHASES = 12;

  // One directed request: settings phase, cycle count, and the result where it is obvious
  typedef struct packed {
    logic [2:0]       ph;
    logic [CYC_W-1:0] cycles;
    logic             typed;
    res_t             want;
  } step_row_t;

  localparam res_t ANY = '0;

  // Columns: phase, cycles, typed, {timer_interrupt, timer_value, divider_value}
  localparam step_row_t STEP_ROWS [0:21] = '{
    // reset settings: timer off, divider alone
    '{3'd0, 8'd0,   1'b1, '{1'b0, 8'h00, 8'h00}},
    '{3'd0, 8'd255, 1'b1, '{1'b0, 8'h00, 8'h00}},
    '{3'd0, 8'd1,   1'b1, '{1'b0, 8'h00, 8'h01}},
    '{3'd0, 8'd255, 1'b1, '{1'b0, 8'h00, 8'h01}},
    // overshoot past the divider period; the excess is lost
    '{3'd0, 8'd255, 1'b1, '{1'b0, 8'h00, 8'h02}},
    '{3'd0, 8'd0,   1'b1, '{1'b0, 8'h00, 8'h02}},
    // timer on, longest period
    '{3'd1, 8'd255, 1'b0, ANY},
    '{3'd1, 8'd255, 1'b0, ANY},
    '{3'd1, 8'd255, 1'b0, ANY},
    '{3'd1, 8'd255, 1'b0, ANY},
    '{3'd1, 8'd0,   1'b0, ANY},
    '{3'd1, 8'd4,   1'b0, ANY},
    '{3'd1, 8'd255, 1'b0, ANY},
    '{3'd1, 8'd255, 1'b0, ANY},
    '{3'd1, 8'd255, 1'b0, ANY},
    '{3'd1, 8'd255, 1'b0, ANY},
    // shorter period while the accumulator is well above it: zero cycles still step
    '{3'd2, 8'd0,   1'b0, ANY},
    '{3'd2, 8'd9,   1'b0, ANY},
    // timer off: accumulator and register hold
    '{3'd3, 8'd200, 1'b0, ANY},
    '{3'd3, 8'd100, 1'b0, ANY},
    // back on with a new period
    '{3'd4, 8'd40,  1'b0, ANY},
    '{3'd4, 8'd30,  1'b0, ANY}
  };

  // Columns: timer_enable, clock_select, reload_value
  localparam cfg_t PHASE_CFG [0:4] = '{
    '{1'b0, CSEL_1024, 8'h00},
    '{1'b1, CSEL_1024, 8'hA5},
    '{1'b1, CSEL_16,   8'hA5},
    '{1'b0, CSEL_16,   8'hA5},
    '{1'b1, CSEL_64,   8'h00}
  };

  // Opening random phases fix the extremes; the rest are drawn at random
  localparam cfg_t RAND_CFG [0:5] = '{
    '{1'b1, CSEL_16,   8'hFF},
    '{1'b1, CSEL_16,   8'h00},
    '{1'b0, CSEL_256,  8'h7F},
    '{1'b1, CSEL_1024, 8'h80},
    '{1'b1, CSEL_256,  8'hFF},
    '{1'b1, CSEL_64,   8'h00}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [7:0] elapsed_cycles
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [7:0] divider, [15:8] timer, [16] interrupt
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]      cfg_paddr = '0;
  logic [PDATA_W-1:0]     cfg_pwdata = '0;
  logic [PDATA_W-1:0]     cfg_prdata;
  logic                   cfg_pready;

  // Predictor state
  logic [DIV_ACC_W-1:0]   div_acc = '0;
  logic [TMR_ACC_W-1:0]   tmr_acc = '0;
  logic [CNT_W-1:0]       div_cnt = '0;
  logic [CNT_W-1:0]       tmr_cnt = '0;
  cfg_t                   timer_cfg = '0;

  res_t counts_due [$];
  int   error_count = 0;
  bit   calm = 1'b0;
  int   send_mode = 1;
  int   sink_mode = 1;
  int   stall_left = 0;

  divider_and_reload_timer u_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("** divider_and_reload_timer: FAILED **");
    $finish;
  end

  function automatic logic [TMR_ACC_W-1:0] timer_period(input logic [1:0] sel);
    logic [TMR_ACC_W-1:0] p;
    case (sel)
      CSEL_1024: p = 11'd1024;
      CSEL_16:   p = 11'd16;
      CSEL_64:   p = 11'd64;
      CSEL_256:  p = 11'd256;
    endcase
    return p;
  endfunction

  // Advance both counters by one request and return the result it should produce
  function automatic res_t tick_counters(input logic [CYC_W-1:0] cyc);
    res_t r;
    r = '0;
    div_acc = div_acc + DIV_ACC_W'(cyc);
    if (div_acc >= DIV_ACC_W'(DIV_PERIOD)) begin
      div_acc = '0;
      div_cnt = div_cnt + CNT_W'(1);
    end
    if (timer_cfg.timer_enable) begin
      tmr_acc = tmr_acc + TMR_ACC_W'(cyc);
      if (tmr_acc >= timer_period(timer_cfg.clock_select)) begin
        tmr_acc = '0;
        if (tmr_cnt == CNT_MAX) begin
          tmr_cnt = timer_cfg.reload_value;
          r.timer_interrupt = 1'b1;
        end else begin
          tmr_cnt = tmr_cnt + CNT_W'(1);
        end
      end
    end
    r.divider_value = div_cnt;
    r.timer_value = tmr_cnt;
    return r;
  endfunction

  // Mirror a register write, keeping only the register's own bits
  function automatic void note_cfg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    case (idx)
      REG_TIMER_ENABLE: timer_cfg.timer_enable = val[0];
      REG_CLOCK_SELECT: timer_cfg.clock_select = val[1:0];
      REG_RELOAD_VALUE: timer_cfg.reload_value = val[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  // Spread counts over the full range, the small end, the top end and the short periods
  function automatic logic [CYC_W-1:0] pick_cycles();
    logic [CYC_W-1:0] c;
    case ($urandom_range(0, 3))
      0:       c = CYC_W'($urandom_range(0, 255));
      1:       c = CYC_W'($urandom_range(0, 20));
      2:       c = CYC_W'($urandom_range(240, 255));
      default: c = CYC_W'($urandom_range(0, 70));
    endcase
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Setup then access phase; psel stays high so writes can follow back to back
  task automatic cfg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    note_cfg_write(idx, val);
  endtask

  // Write every register with junk in the unused bits, poke the empty slot, release the bus
  task automatic load_settings(input cfg_t c);
    cfg_write(REG_UNUSED, $urandom);
    cfg_write(REG_TIMER_ENABLE, ($urandom & ~32'h1) | PDATA_W'(c.timer_enable));
    cfg_write(REG_CLOCK_SELECT, ($urandom & ~32'h3) | PDATA_W'(c.clock_select));
    cfg_write(REG_RELOAD_VALUE, ($urandom & ~32'hFF) | PDATA_W'(c.reload_value));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Hold off requests until every expected result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (counts_due.size() != 0) @(posedge clk);
  endtask

  // Present one request, wait for acceptance, queue what it should yield
  task automatic send_item(input logic [CYC_W-1:0] cyc, input logic typed, input res_t want);
    res_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= cyc;
    do @(posedge clk); while (!in_tready);
    r = tick_counters(cyc);
    counts_due.push_back(typed ? want : r);
  endtask

  // Result side: check each accepted result, then choose the next ready level
  always @(posedge clk) begin : result_sink
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[16:0]);
      if (counts_due.size() == 0) begin
        report_mismatch("unexpected result", int'(out_tdata), 0);
      end else begin
        want = counts_due.pop_front();
        if (got.divider_value != want.divider_value)
          report_mismatch("divider_value", int'(got.divider_value),
                          int'(want.divider_value));
        if (got.timer_value != want.timer_value)
          report_mismatch("timer_value", int'(got.timer_value), int'(want.timer_value));
        if (got.timer_interrupt != want.timer_interrupt)
          report_mismatch("timer_interrupt", int'(got.timer_interrupt),
                          int'(want.timer_interrupt));
      end
      if (out_tdata[OUT_TDATA_W-1:17] != '0)
        report_mismatch("tdata padding", int'(out_tdata[OUT_TDATA_W-1:17]), 0);
    end
    // Stall in bursts of random length
    if (calm || sink_mode == 0) begin
      out_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, (sink_mode == 1) ? 9 : 3) == 0) begin
      stall_left = int'($urandom_range(0, 15));
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    cfg_t c;
    int   n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; settings change only between phases with nothing in flight
    for (int i = 0; i < $size(STEP_ROWS); i++) begin
      if (i > 0 && STEP_ROWS[i].ph != STEP_ROWS[i-1].ph) begin
        drain();
        load_settings(PHASE_CFG[STEP_ROWS[i].ph]);
      end
      send_item(STEP_ROWS[i].cycles, STEP_ROWS[i].typed, STEP_ROWS[i].want);
    end

    // Random phases; the last one runs without gaps on either side
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      if (ph < $size(RAND_CFG)) begin
        c = RAND_CFG[ph];
      end else begin
        c.timer_enable = ($urandom_range(0, 3) != 0);
        c.clock_select = 2'($urandom_range(0, 3));
        c.reload_value = CNT_W'($urandom_range(0, 255));
      end
      load_settings(c);
      calm = (ph == RAND_PHASES - 1);
      send_mode = (ph == 0) ? 1 : int'($urandom_range(0, 2));
      sink_mode = (ph == 0) ? 2 : int'($urandom_range(0, 2));
      // long first phase so the timer climbs to 0xFF and reloads repeatedly
      n = (ph == 0) ? 400 : 130;
      for (int k = 0; k < n; k++) begin
        if (!calm && send_mode != 0 && $urandom_range(0, (send_mode == 1) ? 9 : 3) == 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        send_item(pick_cycles(), 1'b0, ANY);
      end
    end

    // Let the pipeline empty and catch any stray result
    drain();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("** divider_and_reload_timer: PASSED **");
    end else begin
      $display("** divider_and_reload_timer: FAILED **");
    end
    $finish;
  end

endmodule
